@@ rtl/ppu_pkg.sv @@
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants for the pruning partials update block.
// ----------------------------------------------------------------------------
package ppu_pkg;

  localparam int STATES     = 4;
  localparam int CATEGORIES = 4;
  localparam int SIDES      = 2;
  localparam int BANKS      = SIDES * STATES;
  localparam int CAT_W      = 2;
  localparam int ROW_W      = 2;
  localparam int PROD_W     = 33;
  localparam int SUM_W      = 35;

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [31:0] MAX_Q31 = 32'hFFFF_FFFF;

  localparam logic       OP_LOAD    = 1'b0;
  localparam logic       OP_COMPUTE = 1'b1;
  localparam logic [2:0] CODE_UNKNOWN  = 3'd4;
  localparam logic [2:0] CODE_PARTIALS = 3'd5;

  localparam int IN_DATA_W  = 272;
  localparam int OUT_DATA_W = 128;

  typedef logic [31:0]              word_t;
  typedef logic [STATES-1:0][31:0]  row_t;
  typedef logic [PROD_W-1:0]        prod_t;

  // Request from the top level to the matrix store
  typedef struct packed {
    logic             wr_en;
    logic             wr_side;
    logic [ROW_W-1:0] wr_row;
    logic [CAT_W-1:0] wr_cat;
    logic             rd_en;
    logic [CAT_W-1:0] rd_cat;
  } store_req_t;

  // Clamp a wide unsigned value to the Q1.31 range
  function automatic word_t sat_word(input logic [SUM_W-1:0] x);
    word_t r;
    if (x[SUM_W-1:32] != '0) r = MAX_Q31;
    else r = x[31:0];
    return r;
  endfunction

endpackage

@@ rtl/pruning_partials_update.sv @@
// ----------------------------------------------------------------------------
// pruning_partials_update
// One node step of the pruning kernel for four nucleotide states.
// ----------------------------------------------------------------------------
// Input words arrive on s_t*; s_tuser is the operation. A load word writes
// one row of a child's transition matrix (index = side*16+category*4+row,
// row entries in left_v0..3) and returns nothing. A compute word gives the
// category in index and the two children; it returns one word of four
// parent partials on m_t*, Q1.31, truncated products, saturated sums.
// A compute word with a category of four or more returns nothing.
// Throughput is one word per cycle while s_tready is high. A result passes,
// after its word is accepted, through the matrix bank read at the accept
// edge, then products, child terms, parent product and the output register.
// The matrices sit in eight banks (side by row), all read at the category
// in the accept cycle, so a compute right after a load sees the new row.
// When m_tready is low, the output register holds and a skid register takes
// one more result; s_tready then drops until the skid register drains.
// Reset clears the pipeline and output valid bits; the matrix banks are
// undefined until loaded.
// ----------------------------------------------------------------------------
module pruning_partials_update (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // index, left_code, right_code, left_v0..3, right_v0..3, zero pad
  input  logic [ppu_pkg::IN_DATA_W-1:0]      s_tdata,
  // operation
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // parent_p0, parent_p1, parent_p2, parent_p3
  output logic [ppu_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import ppu_pkg::*;

  logic       advance;
  logic       accept;
  logic [4:0] index;
  logic [2:0] left_code;
  logic [2:0] right_code;
  row_t       left_v;
  row_t       right_v;
  store_req_t req;
  row_t       mat [BANKS];
  logic       res_valid;
  row_t       res_data;
  row_t       out_data;

  // Unpack the input word
  assign index      = s_tdata[4:0];
  assign left_code  = s_tdata[7:5];
  assign right_code = s_tdata[10:8];
  assign left_v     = s_tdata[138:11];
  assign right_v    = s_tdata[266:139];

  assign s_tready = advance;
  assign accept   = s_tvalid && s_tready;

  // Build the store request
  always_comb begin
    req.wr_en   = accept && (s_tuser == OP_LOAD);
    req.wr_side = index[4];
    req.wr_cat  = index[3:2];
    req.wr_row  = index[1:0];
    req.rd_en   = advance;
    req.rd_cat  = index[CAT_W-1:0];
  end

  ppu_matrix_store u_store (
    .clk     (clk),
    .req     (req),
    .wr_data (left_v),
    .rd_data (mat)
  );

  ppu_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (accept && (s_tuser == OP_COMPUTE) && (32'(index) < CATEGORIES)),
    .left_code  (left_code),
    .right_code (right_code),
    .left_v     (left_v),
    .right_v    (right_v),
    .mat        (mat),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  ppu_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_data  (res_data),
    .advance   (advance),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = out_data;

endmodule

@@ rtl/ppu_matrix_store.sv @@
// ----------------------------------------------------------------------------
// ppu_matrix_store
// Transition matrix store: one bank per side and matrix row, indexed by
// rate category. A load writes one bank; a compute reads all banks.
// ----------------------------------------------------------------------------
module ppu_matrix_store (
  input  logic                clk,
  input  ppu_pkg::store_req_t req,
  input  ppu_pkg::row_t       wr_data,
  output ppu_pkg::row_t       rd_data [ppu_pkg::BANKS]
);
  import ppu_pkg::*;

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    row_t mem [CATEGORIES];

    // Write the row that the load selects
    always_ff @(posedge clk) begin
      if (req.wr_en && ({req.wr_side, req.wr_row} == ($clog2(BANKS))'(b))) begin
        mem[req.wr_cat] <= wr_data;
      end
    end

    // Registered read, held while the pipeline stalls
    always_ff @(posedge clk) begin
      if (req.rd_en) begin
        rd_data[b] <= mem[req.rd_cat];
      end
    end
  end

endmodule

@@ rtl/ppu_datapath.sv @@
// ----------------------------------------------------------------------------
// ppu_datapath
// Product and reduction pipeline: matrix-by-partials products, child terms,
// parent product. All stages move together on advance.
// ----------------------------------------------------------------------------
module ppu_datapath (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          in_valid,
  input  logic [2:0]    left_code,
  input  logic [2:0]    right_code,
  input  ppu_pkg::row_t left_v,
  input  ppu_pkg::row_t right_v,
  input  ppu_pkg::row_t mat [ppu_pkg::BANKS],
  output logic          res_valid,
  output ppu_pkg::row_t res_data
);
  import ppu_pkg::*;

  // stage 1: item beside the memory read data
  logic       v1;
  logic [2:0] code1 [SIDES];
  row_t       vec1 [SIDES];

  // stage 2: products and tip terms
  logic       v2;
  logic [2:0] code2 [SIDES];
  prod_t      prod2 [SIDES][STATES][STATES];
  word_t      tip2 [SIDES][STATES];

  // stage 3: child terms
  logic       v3;
  word_t      term3 [SIDES][STATES];

  // stage 4: parent products
  logic       v4;
  prod_t      par4 [STATES];

  logic [63:0]      mul_full [SIDES][STATES][STATES];
  logic [SUM_W-1:0] dot_sum  [SIDES][STATES];
  logic [63:0]      par_full [STATES];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Hold the item next to the read data
  always_ff @(posedge clk) begin
    if (advance) begin
      code1[0] <= left_code;
      code1[1] <= right_code;
      vec1[0]  <= left_v;
      vec1[1]  <= right_v;
    end
  end

  // Form matrix-by-partials products
  always_comb begin
    for (int s = 0; s < SIDES; s++) begin
      for (int r = 0; r < STATES; r++) begin
        for (int j = 0; j < STATES; j++) begin
          mul_full[s][r][j] = 64'(mat[s*STATES + r][j]) * 64'(vec1[s][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int s = 0; s < SIDES; s++) begin
        code2[s] <= code1[s];
        for (int r = 0; r < STATES; r++) begin
          for (int j = 0; j < STATES; j++) begin
            prod2[s][r][j] <= mul_full[s][r][j][31 +: PROD_W];
          end
          if (code1[s] < CODE_UNKNOWN) tip2[s][r] <= mat[s*STATES + r][code1[s][1:0]];
          else tip2[s][r] <= ONE_Q31;
        end
      end
    end
  end

  // Reduce dot products and pick each child term
  always_comb begin
    for (int s = 0; s < SIDES; s++) begin
      for (int r = 0; r < STATES; r++) begin
        dot_sum[s][r] = SUM_W'(prod2[s][r][0]) + SUM_W'(prod2[s][r][1])
                      + SUM_W'(prod2[s][r][2]) + SUM_W'(prod2[s][r][3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int s = 0; s < SIDES; s++) begin
        for (int r = 0; r < STATES; r++) begin
          if (code2[s] == CODE_PARTIALS) term3[s][r] <= sat_word(dot_sum[s][r]);
          else term3[s][r] <= tip2[s][r];
        end
      end
    end
  end

  // Multiply left and right terms
  always_comb begin
    for (int r = 0; r < STATES; r++) begin
      par_full[r] = 64'(term3[0][r]) * 64'(term3[1][r]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < STATES; r++) begin
        par4[r] <= par_full[r][31 +: PROD_W];
      end
    end
  end

  assign res_valid = v4;
  always_comb begin
    for (int r = 0; r < STATES; r++) begin
      res_data[r] = sat_word(SUM_W'(par4[r]));
    end
  end

endmodule

@@ rtl/ppu_out_skid.sv @@
// ----------------------------------------------------------------------------
// ppu_out_skid
// Output register with a skid stage; stalls the pipeline only when full.
// ----------------------------------------------------------------------------
module ppu_out_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_valid,
  input  ppu_pkg::row_t res_data,
  output logic          advance,
  output logic          out_valid,
  input  logic          out_ready,
  output ppu_pkg::row_t out_data
);
  import ppu_pkg::*;

  logic skid_valid;
  row_t skid_data;
  logic pop;

  assign advance = !skid_valid;
  assign pop     = out_valid && out_ready;

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payload words
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_data <= skid_data;
    end else if (!out_valid || pop) begin
      out_data <= res_data;
    end else if (res_valid) begin
      skid_data <= res_data;
    end
  end

endmodule

@@ rtl/ppu_checker.sv @@
// ----------------------------------------------------------------------------
// ppu_checker
// Port-level checks for the pruning partials update block.
// ----------------------------------------------------------------------------
module ppu_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ppu_pkg::OUT_DATA_W-1:0] m_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // No result can leave before the pipeline fills after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid ##1 !m_tvalid ##1 !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
    else $error("result too soon after reset");

  // Input stalls only behind a held result
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind pruning_partials_update ppu_checker u_ppu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
